// File: design/stl_pkg.sv
// Shared types, token kind codes and the keyword table of the source text lexer.
package stl_pkg;

  // Counter width of lengths, lines and columns (ports are fixed at 16 bits)
  localparam int COUNT_BITS    = 16;
  // Identifier bytes kept for keyword matching
  localparam int KEYWORD_CHARS = 10;
  localparam int KW_IDX_W      = $clog2(KEYWORD_CHARS);
  localparam int KW_LEN_W      = $clog2(KEYWORD_CHARS + 1);
  localparam int NUM_KW        = 21;
  localparam int KIND_W        = 6;

  // Result queue
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  // Token kinds
  localparam logic [KIND_W-1:0] KIND_IDENT      = 6'd0;
  localparam logic [KIND_W-1:0] KIND_TYPE_NAME  = 6'd1;
  localparam logic [KIND_W-1:0] KIND_INT        = 6'd2;
  localparam logic [KIND_W-1:0] KIND_FLOAT      = 6'd3;
  localparam logic [KIND_W-1:0] KIND_BOOL       = 6'd4;
  localparam logic [KIND_W-1:0] KIND_STRING     = 6'd5;
  localparam logic [KIND_W-1:0] KIND_OPER       = 6'd6;
  localparam logic [KIND_W-1:0] KIND_EQ         = 6'd7;
  localparam logic [KIND_W-1:0] KIND_LPAREN     = 6'd8;
  localparam logic [KIND_W-1:0] KIND_RPAREN     = 6'd9;
  localparam logic [KIND_W-1:0] KIND_LBRACE     = 6'd10;
  localparam logic [KIND_W-1:0] KIND_RBRACE     = 6'd11;
  localparam logic [KIND_W-1:0] KIND_SEMI       = 6'd12;
  localparam logic [KIND_W-1:0] KIND_DOT        = 6'd13;
  localparam logic [KIND_W-1:0] KIND_COMMA      = 6'd14;
  localparam logic [KIND_W-1:0] KIND_FNC        = 6'd15;
  localparam logic [KIND_W-1:0] KIND_EXTERN     = 6'd16;
  localparam logic [KIND_W-1:0] KIND_OPERATOR   = 6'd17;
  localparam logic [KIND_W-1:0] KIND_INCLUDE    = 6'd18;
  localparam logic [KIND_W-1:0] KIND_TYPE_KW    = 6'd19;
  localparam logic [KIND_W-1:0] KIND_REF        = 6'd20;
  localparam logic [KIND_W-1:0] KIND_VAL        = 6'd21;
  localparam logic [KIND_W-1:0] KIND_IMPLEMENT  = 6'd22;
  localparam logic [KIND_W-1:0] KIND_FOR        = 6'd23;
  localparam logic [KIND_W-1:0] KIND_DESTRUCTOR = 6'd24;
  localparam logic [KIND_W-1:0] KIND_GENERIC    = 6'd25;
  localparam logic [KIND_W-1:0] KIND_IF         = 6'd26;
  localparam logic [KIND_W-1:0] KIND_WHILE      = 6'd27;
  localparam logic [KIND_W-1:0] KIND_ELSE       = 6'd28;
  localparam logic [KIND_W-1:0] KIND_RET        = 6'd29;
  localparam logic [KIND_W-1:0] KIND_UNKNOWN    = 6'd30;
  localparam logic [KIND_W-1:0] KIND_EOF        = 6'd31;
  localparam logic [KIND_W-1:0] KIND_UNTERM     = 6'd32;

  // Lexer mode, one-hot
  typedef enum logic [5:0] {
    MODE_IDLE = 6'b000001,
    MODE_WORD = 6'b000010,
    MODE_NUM  = 6'b000100,
    MODE_OPER = 6'b001000,
    MODE_EQ   = 6'b010000,
    MODE_STR  = 6'b100000
  } lex_mode_e;

  // One token descriptor
  typedef struct packed {
    logic [KIND_W-1:0]     kind;
    logic [COUNT_BITS-1:0] token_length;
    logic [COUNT_BITS-1:0] start_line;
    logic [COUNT_BITS-1:0] start_column;
    logic                  last;
  } result_t;

  // Results of one byte, r0 first; n is 0, 1 or 2
  typedef struct packed {
    logic [1:0] n;
    result_t    r0;
    result_t    r1;
  } push_t;

  // Result queue status
  typedef struct packed {
    logic [FIFO_CNT_W-1:0] count;
    logic                  room;
  } fifo_status_t;

  // Keyword table entry; text holds the word right-justified, last char in byte 0
  typedef struct packed {
    logic [KEYWORD_CHARS-1:0][7:0] text;
    logic [KW_LEN_W-1:0]           len;
    logic [KIND_W-1:0]             kind;
  } kw_entry_t;

  localparam kw_entry_t KW_TABLE [NUM_KW] = '{
    '{text: "fnc",        len: KW_LEN_W'(3),  kind: KIND_FNC},
    '{text: "extern",     len: KW_LEN_W'(6),  kind: KIND_EXTERN},
    '{text: "operator",   len: KW_LEN_W'(8),  kind: KIND_OPERATOR},
    '{text: "include",    len: KW_LEN_W'(7),  kind: KIND_INCLUDE},
    '{text: "type",       len: KW_LEN_W'(4),  kind: KIND_TYPE_KW},
    '{text: "ref",        len: KW_LEN_W'(3),  kind: KIND_REF},
    '{text: "val",        len: KW_LEN_W'(3),  kind: KIND_VAL},
    '{text: "implement",  len: KW_LEN_W'(9),  kind: KIND_IMPLEMENT},
    '{text: "for",        len: KW_LEN_W'(3),  kind: KIND_FOR},
    '{text: "destructor", len: KW_LEN_W'(10), kind: KIND_DESTRUCTOR},
    '{text: "generic",    len: KW_LEN_W'(7),  kind: KIND_GENERIC},
    '{text: "int",        len: KW_LEN_W'(3),  kind: KIND_TYPE_NAME},
    '{text: "float",      len: KW_LEN_W'(5),  kind: KIND_TYPE_NAME},
    '{text: "bool",       len: KW_LEN_W'(4),  kind: KIND_TYPE_NAME},
    '{text: "str",        len: KW_LEN_W'(3),  kind: KIND_TYPE_NAME},
    '{text: "true",       len: KW_LEN_W'(4),  kind: KIND_BOOL},
    '{text: "false",      len: KW_LEN_W'(5),  kind: KIND_BOOL},
    '{text: "if",         len: KW_LEN_W'(2),  kind: KIND_IF},
    '{text: "while",      len: KW_LEN_W'(5),  kind: KIND_WHILE},
    '{text: "else",       len: KW_LEN_W'(4),  kind: KIND_ELSE},
    '{text: "ret",        len: KW_LEN_W'(3),  kind: KIND_RET}
  };

  // Saturating increment
  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
    return (&v) ? v : v + 1'b1;
  endfunction

  // Parallel compare of the held identifier against every keyword
  function automatic logic [KIND_W-1:0] word_kind(
    input logic [KEYWORD_CHARS-1:0][7:0] wbuf,
    input logic [COUNT_BITS-1:0]         len
  );
    logic [KIND_W-1:0] kind;
    logic              hit;
    kind = KIND_IDENT;
    if (len <= COUNT_BITS'(KEYWORD_CHARS)) begin
      for (int e = 0; e < NUM_KW; e++) begin
        hit = (COUNT_BITS'(KW_TABLE[e].len) == len);
        for (int j = 0; j < KEYWORD_CHARS; j++) begin
          if (j < int'(KW_TABLE[e].len)) begin
            hit = hit && (wbuf[j] == KW_TABLE[e].text[int'(KW_TABLE[e].len) - 1 - j]);
          end
        end
        if (hit) begin
          kind = KW_TABLE[e].kind;
        end
      end
    end
    return kind;
  endfunction

endpackage

// File: design/stl_core.sv
// Lexer state and per-byte token logic: classifies one byte, emits up to two descriptors.
module stl_core (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           accept_i,
  input  logic           op_i,
  input  logic [7:0]     ch_i,
  output stl_pkg::push_t push_o
);
  import stl_pkg::*;

  lex_mode_e                     mode_q, mode_d;
  logic [KEYWORD_CHARS-1:0][7:0] word_buf_q, word_buf_d;
  logic [COUNT_BITS-1:0]         plen_q, plen_d;
  logic                          point_q, point_d;
  logic [COUNT_BITS-1:0]         tok_line_q, tok_line_d;
  logic [COUNT_BITS-1:0]         tok_col_q, tok_col_d;
  logic [COUNT_BITS-1:0]         line_q, line_d;
  logic [COUNT_BITS-1:0]         col_q, col_d;

  logic                  is_letter, is_digit, is_space, is_op, is_eq, is_quote;
  logic [KIND_W-1:0]     punct_kind;
  logic [COUNT_BITS-1:0] col_inc;
  logic [KIND_W-1:0]     flush_kind;
  logic [COUNT_BITS-1:0] flush_len;
  logic                  first_v, sec_v, do_disp;
  logic [KIND_W-1:0]     first_kind, sec_kind;
  logic [COUNT_BITS-1:0] first_len, sec_len;
  result_t               first_r, sec_r;

  // Byte classes
  always_comb begin
    is_letter = (ch_i >= "a" && ch_i <= "z") || (ch_i >= "A" && ch_i <= "Z") || ch_i == "_";
    is_digit  = ch_i >= "0" && ch_i <= "9";
    is_space  = ch_i == " " || (ch_i >= 8'd9 && ch_i <= 8'd13);
    is_op     = ch_i == "!" || ch_i == "~" || ch_i == "@" || ch_i == "#" || ch_i == "$" ||
                ch_i == "%" || ch_i == "^" || ch_i == "&" || ch_i == "*" || ch_i == "-" ||
                ch_i == "+" || ch_i == "\\" || ch_i == "/" || ch_i == "<" || ch_i == ">";
    is_eq     = ch_i == "=";
    is_quote  = ch_i == "\"";
    unique case (ch_i)
      "(":     punct_kind = KIND_LPAREN;
      ")":     punct_kind = KIND_RPAREN;
      "{":     punct_kind = KIND_LBRACE;
      "}":     punct_kind = KIND_RBRACE;
      ";":     punct_kind = KIND_SEMI;
      ".":     punct_kind = KIND_DOT;
      ",":     punct_kind = KIND_COMMA;
      default: punct_kind = KIND_UNKNOWN;
    endcase
  end

  assign col_inc = sat_inc(col_q);

  // Descriptor of the token held in the current mode
  always_comb begin
    flush_len = plen_q;
    unique case (mode_q)
      MODE_WORD: flush_kind = word_kind(word_buf_q, plen_q);
      MODE_NUM:  flush_kind = point_q ? KIND_FLOAT : KIND_INT;
      MODE_OPER: flush_kind = KIND_OPER;
      MODE_EQ: begin
        flush_kind = KIND_EQ;
        flush_len  = COUNT_BITS'(1);
      end
      MODE_STR:  flush_kind = KIND_UNTERM;
      default:   flush_kind = KIND_IDENT;
    endcase
  end

  // Next state and emitted descriptors
  always_comb begin
    mode_d     = mode_q;
    word_buf_d = word_buf_q;
    plen_d     = plen_q;
    point_d    = point_q;
    tok_line_d = tok_line_q;
    tok_col_d  = tok_col_q;
    line_d     = line_q;
    col_d      = col_q;
    first_v    = 1'b0;
    first_kind = flush_kind;
    first_len  = flush_len;
    sec_v      = 1'b0;
    sec_kind   = punct_kind;
    sec_len    = COUNT_BITS'(1);
    do_disp    = 1'b0;

    if (accept_i) begin
      if (op_i) begin
        // end of text: pending token, then the end marker
        first_v  = (mode_q != MODE_IDLE);
        sec_v    = 1'b1;
        sec_kind = KIND_EOF;
        sec_len  = '0;
        mode_d   = MODE_IDLE;
      end else begin
        col_d = col_inc;
        unique case (mode_q)
          MODE_STR: begin
            if (is_quote) begin
              first_v    = 1'b1;
              first_kind = KIND_STRING;
              mode_d     = MODE_IDLE;
            end else begin
              plen_d = sat_inc(plen_q);
            end
          end
          MODE_WORD: begin
            if (is_letter || is_digit) begin
              if (plen_q < COUNT_BITS'(KEYWORD_CHARS)) begin
                word_buf_d[plen_q[KW_IDX_W-1:0]] = ch_i;
              end
              plen_d = sat_inc(plen_q);
            end else begin
              first_v = 1'b1;
              do_disp = 1'b1;
            end
          end
          MODE_NUM: begin
            if (is_digit || ch_i == ".") begin
              if (ch_i == ".") begin
                point_d = 1'b1;
              end
              plen_d = sat_inc(plen_q);
            end else begin
              first_v = 1'b1;
              do_disp = 1'b1;
            end
          end
          MODE_OPER: begin
            if (is_op || is_eq) begin
              plen_d = sat_inc(plen_q);
            end else begin
              first_v = 1'b1;
              do_disp = 1'b1;
            end
          end
          MODE_EQ: begin
            if (is_eq) begin
              first_v    = 1'b1;
              first_kind = KIND_OPER;
              first_len  = COUNT_BITS'(2);
              mode_d     = MODE_IDLE;
            end else begin
              first_v = 1'b1;
              do_disp = 1'b1;
            end
          end
          default: do_disp = 1'b1;
        endcase

        // this byte opens a new token or stands alone
        if (do_disp) begin
          mode_d     = MODE_IDLE;
          tok_line_d = line_q;
          tok_col_d  = col_inc;
          plen_d     = COUNT_BITS'(1);
          point_d    = 1'b0;
          priority if (is_space) begin
            tok_line_d = tok_line_q;
            tok_col_d  = tok_col_q;
            plen_d     = plen_q;
            point_d    = point_q;
          end else if (is_quote) begin
            mode_d = MODE_STR;
            plen_d = '0;
          end else if (is_letter) begin
            mode_d        = MODE_WORD;
            word_buf_d[0] = ch_i;
          end else if (is_digit) begin
            mode_d = MODE_NUM;
          end else if (is_op) begin
            mode_d = MODE_OPER;
          end else if (is_eq) begin
            mode_d = MODE_EQ;
          end else begin
            sec_v      = 1'b1;
            tok_line_d = tok_line_q;
            tok_col_d  = tok_col_q;
            plen_d     = plen_q;
            point_d    = point_q;
          end
        end

        if (ch_i == 8'h0a) begin
          line_d = sat_inc(line_q);
          col_d  = '0;
        end
      end
    end
  end

  // Pack the results in order, marking the final one
  always_comb begin
    first_r = '{kind: first_kind, token_length: first_len, start_line: tok_line_q,
                start_column: tok_col_q, last: !sec_v};
    sec_r   = '{kind: sec_kind, token_length: sec_len, start_line: line_q,
                start_column: col_inc, last: 1'b1};
    push_o.n = {1'b0, first_v} + {1'b0, sec_v};
    if (first_v) begin
      push_o.r0 = first_r;
      push_o.r1 = sec_r;
    end else begin
      push_o.r0 = sec_r;
      push_o.r1 = sec_r;
    end
  end

  // Control and position state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= MODE_IDLE;
      plen_q     <= '0;
      point_q    <= 1'b0;
      tok_line_q <= '0;
      tok_col_q  <= '0;
      line_q     <= COUNT_BITS'(1);
      col_q      <= '0;
    end else begin
      mode_q     <= mode_d;
      plen_q     <= plen_d;
      point_q    <= point_d;
      tok_line_q <= tok_line_d;
      tok_col_q  <= tok_col_d;
      line_q     <= line_d;
      col_q      <= col_d;
    end
  end

  // Identifier bytes, no reset
  always_ff @(posedge clk_i) begin
    word_buf_q <= word_buf_d;
  end

endmodule

// File: design/stl_fifo.sv
// Result queue: takes up to two descriptors per cycle, delivers one word per handshake.
module stl_fifo (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  stl_pkg::push_t        push_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output stl_pkg::result_t      result_o,
  output stl_pkg::fifo_status_t status_o
);
  import stl_pkg::*;

  result_t               mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_q, wr_ptr_d, wr_ptr_nx;
  logic [FIFO_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [FIFO_CNT_W-1:0] count_q, count_d;
  logic                  pop;

  assign pop       = out_valid_o && out_ready_i;
  assign wr_ptr_nx = wr_ptr_q + 1'b1;
  assign wr_ptr_d  = wr_ptr_q + FIFO_PTR_W'(push_i.n);
  assign rd_ptr_d  = rd_ptr_q + FIFO_PTR_W'(pop);
  assign count_d   = count_q + FIFO_CNT_W'(push_i.n) - FIFO_CNT_W'(pop);

  assign out_valid_o     = (count_q != '0);
  assign result_o        = mem_q[rd_ptr_q];
  assign status_o.count  = count_q;
  assign status_o.room   = (count_q <= FIFO_CNT_W'(FIFO_DEPTH - 2));

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i.n != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.r0;
    end
    if (push_i.n == 2'd2) begin
      mem_q[wr_ptr_nx] <= push_i.r1;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

// File: design/source_text_lexer.sv
// Source text lexer top level: one text byte in per cycle, token descriptors out.
// Each descriptor is registered in the result queue and offered behind any older words.
// Throughput: one byte per cycle while in_ready_o is high; a byte that ends one token and
// emits another gives two words that leave one at a time through a four-entry result queue.
// in_ready_o drops while the queue has fewer than two free entries.
// Reset: idle between tokens, line 1, column 0, queue empty; no clearing pass.
module source_text_lexer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        op_i,
  input  logic [7:0]  ch_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [5:0]  kind_o,
  output logic [15:0] token_length_o,
  output logic [15:0] start_line_o,
  output logic [15:0] start_column_o,
  output logic        last_o
);
  import stl_pkg::*;

  logic         accept;
  push_t        push;
  result_t      result;
  fifo_status_t status;

  assign in_ready_o = status.room;
  assign accept     = in_valid_i && in_ready_o;

  // Lexer core
  stl_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .op_i     (op_i),
    .ch_i     (ch_i),
    .push_o   (push)
  );

  // Result queue
  stl_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .result_o    (result),
    .status_o    (status)
  );

  assign kind_o         = result.kind;
  assign token_length_o = result.token_length;
  assign start_line_o   = result.start_line;
  assign start_column_o = result.start_column;
  assign last_o         = result.last;

  // End of text always leaves at least its end marker waiting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && op_i) |=> out_valid_o)
    else $error("end of text accepted but no word waiting");

  // Queue never overfills
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.count <= FIFO_CNT_W'(FIFO_DEPTH))
    else $error("result queue overflow");

  // A pair of results carries last only on the second
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push.n == 2'd2) |-> (push.r1.last && !push.r0.last))
    else $error("wrong last marking on a result pair");

  // Nothing is pushed without an accepted word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept |-> (push.n == 2'd0))
    else $error("result pushed without input");

endmodule

// File: tb/sv/stl_token_checker.sv
// Token predictor and checker for the source text lexer, watching both channels.
`timescale 1ns / 100ps
module stl_token_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic        op_i,
  input  logic [7:0]  ch_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [5:0]  kind_i,
  input  logic [15:0] token_length_i,
  input  logic [15:0] start_line_i,
  input  logic [15:0] start_column_i,
  input  logic        last_i,
  output int          mismatches_o,
  output int          pending_o
);
  import stl_pkg::*;

  localparam logic [7:0] CH_QUOTE   = 8'h22;
  localparam logic [7:0] CH_NL      = 8'h0A;

  // Lexer state as predicted
  lex_mode_e             mode_q;
  logic [7:0]            word_chars [KEYWORD_CHARS];
  logic [COUNT_BITS-1:0] tok_len;
  logic [COUNT_BITS-1:0] tok_line;
  logic [COUNT_BITS-1:0] tok_col;
  logic [COUNT_BITS-1:0] line_no;
  logic [COUNT_BITS-1:0] col_no;
  logic                  has_point;

  // Token words predicted but not yet seen on the output
  result_t awaited_tokens [$];

  function automatic logic [COUNT_BITS-1:0] count_up(input logic [COUNT_BITS-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  // Character classes
  function automatic bit is_alpha(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic bit is_num(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_blank(input logic [7:0] c);
    return c == " " || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic bit is_op_char(input logic [7:0] c);
    case (c)
      "!", "~", "@", "#", "$", "%", "^", "&", "*", "-", "+", "\\", "/", "<", ">":
        return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic logic [KIND_W-1:0] punct_kind(input logic [7:0] c);
    case (c)
      "(":     return KIND_LPAREN;
      ")":     return KIND_RPAREN;
      "{":     return KIND_LBRACE;
      "}":     return KIND_RBRACE;
      ";":     return KIND_SEMI;
      ".":     return KIND_DOT;
      ",":     return KIND_COMMA;
      default: return KIND_UNKNOWN;
    endcase
  endfunction

  // Identifier text against the reserved words
  function automatic logic [KIND_W-1:0] keyword_kind();
    string w;
    w = "";
    if (tok_len > COUNT_BITS'(KEYWORD_CHARS)) return KIND_IDENT;
    for (int i = 0; i < int'(tok_len); i++) w = $sformatf("%s%c", w, word_chars[i]);
    case (w)
      "fnc":                        return KIND_FNC;
      "extern":                     return KIND_EXTERN;
      "operator":                   return KIND_OPERATOR;
      "include":                    return KIND_INCLUDE;
      "type":                       return KIND_TYPE_KW;
      "ref":                        return KIND_REF;
      "val":                        return KIND_VAL;
      "implement":                  return KIND_IMPLEMENT;
      "for":                        return KIND_FOR;
      "destructor":                 return KIND_DESTRUCTOR;
      "generic":                    return KIND_GENERIC;
      "int", "float", "bool", "str": return KIND_TYPE_NAME;
      "true", "false":              return KIND_BOOL;
      "if":                         return KIND_IF;
      "while":                      return KIND_WHILE;
      "else":                       return KIND_ELSE;
      "ret":                        return KIND_RET;
      default:                      return KIND_IDENT;
    endcase
  endfunction

  function automatic void push_token(input logic [KIND_W-1:0] k,
                                     input logic [COUNT_BITS-1:0] len,
                                     input logic [COUNT_BITS-1:0] ln,
                                     input logic [COUNT_BITS-1:0] cl);
    result_t t;
    t.kind         = k;
    t.token_length = len;
    t.start_line   = ln;
    t.start_column = cl;
    t.last         = 1'b0;
    awaited_tokens = {awaited_tokens, t};
  endfunction

  // Emit whatever token is held and go idle
  function automatic void close_token();
    case (mode_q)
      MODE_WORD: push_token(keyword_kind(), tok_len, tok_line, tok_col);
      MODE_NUM:  push_token(has_point ? KIND_FLOAT : KIND_INT, tok_len, tok_line, tok_col);
      MODE_OPER: push_token(KIND_OPER, tok_len, tok_line, tok_col);
      MODE_EQ:   push_token(KIND_EQ, 16'd1, tok_line, tok_col);
      MODE_STR:  push_token(KIND_UNTERM, tok_len, tok_line, tok_col);
      default: ;
    endcase
    mode_q = MODE_IDLE;
  endfunction

  function automatic void begin_token(input lex_mode_e m,
                                      input logic [COUNT_BITS-1:0] ln,
                                      input logic [COUNT_BITS-1:0] cl);
    mode_q    = m;
    tok_line  = ln;
    tok_col   = cl;
    tok_len   = (m == MODE_STR) ? '0 : 16'd1;
    has_point = 1'b0;
  endfunction

  // A byte seen from idle: skip a blank, start a token or emit a one-byte one
  function automatic void open_token(input logic [7:0] c,
                                     input logic [COUNT_BITS-1:0] ln,
                                     input logic [COUNT_BITS-1:0] cl);
    if (is_blank(c)) return;
    if (c == CH_QUOTE) begin
      begin_token(MODE_STR, ln, cl);
    end else if (is_alpha(c)) begin
      begin_token(MODE_WORD, ln, cl);
      word_chars[0] = c;
    end else if (is_num(c)) begin
      begin_token(MODE_NUM, ln, cl);
    end else if (is_op_char(c)) begin
      begin_token(MODE_OPER, ln, cl);
    end else if (c == "=") begin
      begin_token(MODE_EQ, ln, cl);
    end else begin
      push_token(punct_kind(c), 16'd1, ln, cl);
    end
  endfunction

  // One accepted input word
  function automatic void lex_step(input logic eot, input logic [7:0] c);
    int                    base;
    logic [COUNT_BITS-1:0] ln;
    logic [COUNT_BITS-1:0] cl;
    base = awaited_tokens.size();
    if (eot) begin
      close_token();
      push_token(KIND_EOF, '0, line_no, count_up(col_no));
    end else begin
      col_no = count_up(col_no);
      ln     = line_no;
      cl     = col_no;
      case (mode_q)
        MODE_STR: begin
          if (c == CH_QUOTE) begin
            push_token(KIND_STRING, tok_len, tok_line, tok_col);
            mode_q = MODE_IDLE;
          end else begin
            tok_len = count_up(tok_len);
          end
        end
        MODE_WORD: begin
          if (is_alpha(c) || is_num(c)) begin
            if (tok_len < COUNT_BITS'(KEYWORD_CHARS)) word_chars[int'(tok_len)] = c;
            tok_len = count_up(tok_len);
          end else begin
            close_token();
            open_token(c, ln, cl);
          end
        end
        MODE_NUM: begin
          if (is_num(c) || c == ".") begin
            if (c == ".") has_point = 1'b1;
            tok_len = count_up(tok_len);
          end else begin
            close_token();
            open_token(c, ln, cl);
          end
        end
        MODE_OPER: begin
          if (is_op_char(c) || c == "=") begin
            tok_len = count_up(tok_len);
          end else begin
            close_token();
            open_token(c, ln, cl);
          end
        end
        MODE_EQ: begin
          if (c == "=") begin
            push_token(KIND_OPER, 16'd2, tok_line, tok_col);
            mode_q = MODE_IDLE;
          end else begin
            close_token();
            open_token(c, ln, cl);
          end
        end
        default: begin
          mode_q = MODE_IDLE;
          open_token(c, ln, cl);
        end
      endcase
      if (c == CH_NL) begin
        line_no = count_up(line_no);
        col_no  = '0;
      end
    end
    if (awaited_tokens.size() > base) awaited_tokens[awaited_tokens.size() - 1].last = 1'b1;
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      mismatches_o++;
      $error("%s: expected %0d, actual %0d", name, want, got);
    end
  endfunction

  // One accepted output word against the oldest prediction
  function automatic void compare_token();
    result_t t;
    if (awaited_tokens.size() == 0) begin
      mismatches_o++;
      $error("token word with none awaited: kind %0d, length %0d", kind_i, token_length_i);
      return;
    end
    t = awaited_tokens.pop_front();
    check_field("kind", t.kind, kind_i);
    check_field("token_length", t.token_length, token_length_i);
    check_field("start_line", t.start_line, start_line_i);
    check_field("start_column", t.start_column, start_column_i);
    check_field("last", t.last, last_i);
  endfunction

  // Inputs are predicted before outputs are matched; both at the same edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       = MODE_IDLE;
      tok_len      = '0;
      tok_line     = '0;
      tok_col      = '0;
      has_point    = 1'b0;
      line_no      = 16'd1;
      col_no       = '0;
      mismatches_o = 0;
      pending_o    = 0;
      awaited_tokens.delete();
    end else begin
      if (in_valid_i && in_ready_i) lex_step(op_i, ch_i);
      if (out_valid_i && out_ready_i) compare_token();
      pending_o = awaited_tokens.size();
    end
  end

endmodule

// File: tb/sv/tb_source_text_lexer.sv
// Testbench top of the source text lexer: clock, reset, text stimulus and verdict.
`timescale 1ns / 100ps
module tb_source_text_lexer;
  import stl_pkg::*;

  localparam int         HALF_PERIOD  = 5;
  localparam int         RESET_CYCLES = 8;
  localparam int         IDLE_PCT     = 19;
  localparam int         RANDOM_BYTES = 1800;
  localparam int         CALM_FROM    = 700;
  localparam int         CALM_TO      = 1000;
  localparam int         DRAIN_AT     = 1300;
  localparam int         SETTLE       = 10;
  localparam int         CYCLE_LIMIT  = 1_000_000;
  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_NL        = 8'h0A;
  localparam string      LETTERS      = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";
  localparam string      OPER_SYMS    = "!~@#$%^&*-+\\/<>";
  localparam string      PUNCTS       = "(){};.,";
  localparam string      BLANKS       = " \t\n\013\014\015";
  localparam string      ODD_MARKS    = "?:[]`'|";

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  logic        op        = 1'b0;
  logic [7:0]  ch        = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [5:0]  kind;
  logic [15:0] token_length;
  logic [15:0] start_line;
  logic [15:0] start_column;
  logic        last;
  int          mismatches;
  int          pending;

  bit          calm;
  int          sent;
  int          cycles;
  logic [7:0]  text_q [$];
  string       keywords [21] = '{
    "fnc", "extern", "operator", "include", "type", "ref", "val", "implement", "for",
    "destructor", "generic", "int", "float", "bool", "str", "true", "false", "if",
    "while", "else", "ret"
  };

  source_text_lexer u_top (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .op_i           (op),
    .ch_i           (ch),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .kind_o         (kind),
    .token_length_o (token_length),
    .start_line_o   (start_line),
    .start_column_o (start_column),
    .last_o         (last)
  );

  stl_token_checker u_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_i     (in_ready),
    .op_i           (op),
    .ch_i           (ch),
    .out_valid_i    (out_valid),
    .out_ready_i    (out_ready),
    .kind_i         (kind),
    .token_length_i (token_length),
    .start_line_i   (start_line),
    .start_column_i (start_column),
    .last_i         (last),
    .mismatches_o   (mismatches),
    .pending_o      (pending)
  );

  always #HALF_PERIOD clk = ~clk;

  // Receiver stalls at random, never inside the calm window
  always @(negedge clk) begin
    out_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // Watchdog
  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Verification failed");
    $finish;
  end

  // One word on the input channel, with random gaps ahead of it
  task automatic send_word(input logic eot, input logic [7:0] c);
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    op       <= eot;
    ch       <= c;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
    @(negedge clk);
  endtask

  task automatic send_eot();
    send_word(1'b1, 8'($urandom_range(0, 255)));
  endtask

  task automatic flush_text();
    while (text_q.size() != 0) send_word(1'b0, text_q.pop_front());
  endtask

  // Hold the sender until every predicted token has come out
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // Append one byte to the text waiting to be sent
  function automatic void add_byte(input logic [7:0] b);
    text_q = {text_q, b};
  endfunction

  function automatic void put_str(input string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endfunction

  function automatic logic [7:0] lead_char();
    return LETTERS[$urandom_range(0, LETTERS.len() - 1)];
  endfunction

  function automatic logic [7:0] digit_char();
    return 8'("0" + $urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] word_char();
    return ($urandom_range(0, 3) == 0) ? digit_char() : lead_char();
  endfunction

  function automatic logic [7:0] op_char();
    return OPER_SYMS[$urandom_range(0, OPER_SYMS.len() - 1)];
  endfunction

  // String content: anything but the closing quote, newlines favored
  function automatic logic [7:0] text_char();
    logic [7:0] c;
    if ($urandom_range(0, 5) == 0) return CH_NL;
    do c = 8'($urandom_range(0, 255)); while (c == CH_QUOTE);
    return c;
  endfunction

  // Bytes that fit no token rule
  function automatic logic [7:0] odd_char();
    case ($urandom_range(0, 2))
      0: return ODD_MARKS[$urandom_range(0, ODD_MARKS.len() - 1)];
      1: return ($urandom_range(0, 1) != 0) ? 8'($urandom_range(0, 8))
                                            : 8'($urandom_range(14, 31));
      default: return 8'($urandom_range(127, 255));
    endcase
  endfunction

  // Queue one random token and maybe a separator; end of text is sent at once
  task automatic make_token();
    int    pick;
    int    n;
    string kw;
    pick = $urandom_range(0, 99);
    if (pick < 18) begin
      put_str(keywords[$urandom_range(0, 20)]);
    end else if (pick < 24) begin
      // near miss of a reserved word
      kw = keywords[$urandom_range(0, 20)];
      if ($urandom_range(0, 1) != 0) begin
        put_str(kw.substr(0, kw.len() - 2));
      end else begin
        put_str(kw);
        add_byte(word_char());
      end
    end else if (pick < 40) begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 20) : $urandom_range(1, 10);
      add_byte(lead_char());
      repeat (n - 1) add_byte(word_char());
    end else if (pick < 52) begin
      n = $urandom_range(1, 6);
      add_byte(digit_char());
      repeat (n - 1) add_byte(($urandom_range(0, 4) == 0) ? 8'(".") : digit_char());
    end else if (pick < 62) begin
      n = $urandom_range(1, 3);
      add_byte(op_char());
      repeat (n - 1) add_byte(($urandom_range(0, 3) == 0) ? 8'("=") : op_char());
    end else if (pick < 68) begin
      if ($urandom_range(0, 1) != 0) begin
        put_str("=");
      end else begin
        put_str("==");
      end
    end else if (pick < 80) begin
      add_byte(PUNCTS[$urandom_range(0, PUNCTS.len() - 1)]);
    end else if (pick < 88) begin
      add_byte(CH_QUOTE);
      repeat ($urandom_range(0, 8)) add_byte(text_char());
      add_byte(CH_QUOTE);
    end else if (pick < 94) begin
      add_byte(odd_char());
    end else if (pick < 97) begin
      // end of text, sometimes inside an open string
      if ($urandom_range(0, 2) == 0) begin
        add_byte(CH_QUOTE);
        repeat ($urandom_range(0, 5)) add_byte(text_char());
      end
      flush_text();
      send_eot();
    end else begin
      repeat ($urandom_range(1, 4)) add_byte(8'($urandom_range(0, 255)));
    end
    if ($urandom_range(0, 1) != 0) add_byte(BLANKS[$urandom_range(0, BLANKS.len() - 1)]);
  endtask

  initial begin
    bit         drained_once;
    calm         = 1'b0;
    sent         = 0;
    drained_once = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: punctuation, == and =, unknown bytes, string, float, end of text,
    // unterminated string, and text after end
    put_str("if_2==(){};.,\n");
    add_byte(8'hFF);
    add_byte(8'h00);
    put_str("\"q\"=1.5");
    flush_text();
    send_eot();
    put_str("\"ab");
    flush_text();
    send_eot();

    // Random program-like text with noise
    while (sent < RANDOM_BYTES) begin
      calm = (sent >= CALM_FROM) && (sent < CALM_TO);
      if (!drained_once && sent >= DRAIN_AT) begin
        wait_drained();
        drained_once = 1'b1;
      end
      make_token();
      flush_text();
    end
    calm = 1'b0;
    send_eot();
    wait_drained();

    // A short tail after the pause
    repeat (20) make_token();
    flush_text();
    send_eot();

    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
